FILE: rtl/tpbb_pkg.sv
// Shared constants, types and colour tables for the bouncing-box test pattern.
// No dependencies; imported by every module of the block.

package tpbb_pkg;

  localparam int FRAME_WIDTH  = 320;
  localparam int FRAME_HEIGHT = 200;
  localparam int BOX_SIZE     = 32;
  localparam int BORDER_PX    = 2;

  localparam int X_W    = 9;
  localparam int Y_W    = 8;
  localparam int STEP_W = 5;
  localparam int COL_W  = 16;
  localparam int SEQ_W  = 32;

  localparam int LIM_X    = FRAME_WIDTH - BOX_SIZE;
  localparam int LIM_Y    = FRAME_HEIGHT - BOX_SIZE;
  localparam int BAR_ROWS = (FRAME_HEIGHT * 2) / 3;

  // Grey ramp x*255/(FRAME_WIDTH-1) as a multiplication by a scaled reciprocal.
  localparam int          GREY_DIV   = FRAME_WIDTH - 1;
  localparam int          GREY_SHIFT = 26;
  localparam longint      GREY_RECIP = ((64'd1 << GREY_SHIFT) + GREY_DIV - 1) / GREY_DIV;
  localparam longint      GREY_MUL   = 255 * GREY_RECIP;
  localparam int          GREY_MUL_W = 26;
  localparam int          GREY_PROD_W = X_W + GREY_MUL_W;

  localparam logic [STEP_W-1:0] STEP_X_RESET = 5'd3;
  localparam logic [STEP_W-1:0] STEP_Y_RESET = 5'd2;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic REG_STEP_X = 1'b0;
  localparam logic REG_STEP_Y = 1'b1;

  localparam logic [COL_W-1:0] COL_WHITE = 16'hFFFF;
  localparam logic [COL_W-1:0] COL_BLACK = 16'h0000;

  localparam logic [COL_W-1:0] BAR_COLOURS [8] = '{
    16'hFFFF, 16'hFFE0, 16'h07FF, 16'h07E0, 16'hF81F, 16'hF800, 16'h001F, 16'h0000
  };

  // First column of each bar: ceil(k * FRAME_WIDTH / 8).
  localparam logic [X_W:0] BAR_EDGE [8] = '{
    10'd0,
    10'((1 * FRAME_WIDTH + 7) / 8),
    10'((2 * FRAME_WIDTH + 7) / 8),
    10'((3 * FRAME_WIDTH + 7) / 8),
    10'((4 * FRAME_WIDTH + 7) / 8),
    10'((5 * FRAME_WIDTH + 7) / 8),
    10'((6 * FRAME_WIDTH + 7) / 8),
    10'((7 * FRAME_WIDTH + 7) / 8)
  };

  typedef struct packed {
    logic [X_W-1:0] col;
    logic [Y_W-1:0] row;
  } box_pos_t;

endpackage

FILE: rtl/tpbb_axis.sv
// Moves the box along one axis by a step, saturating at zero and the far limit,
// and reports the new direction. Depends on tpbb_pkg.

module tpbb_axis (
  input  logic [tpbb_pkg::X_W-1:0]    pos,
  input  logic [tpbb_pkg::STEP_W-1:0] step,
  input  logic [tpbb_pkg::X_W-1:0]    lim,
  input  logic                        back,
  output logic [tpbb_pkg::X_W-1:0]    pos_nxt,
  output logic                        back_nxt
);
  import tpbb_pkg::*;

  logic [X_W:0]   sum;
  logic [X_W-1:0] moved;

  always_comb begin
    sum = {1'b0, pos} + {{(X_W + 1 - STEP_W){1'b0}}, step};
    if (back) begin
      moved = (pos >= {{(X_W - STEP_W){1'b0}}, step}) ?
              pos - {{(X_W - STEP_W){1'b0}}, step} : '0;
    end else begin
      moved = (sum > {1'b0, lim}) ? lim : sum[X_W-1:0];
    end
    pos_nxt  = (moved > lim) ? lim : moved;
    back_nxt = back ^ ((pos_nxt == '0) || (pos_nxt >= lim));
  end

endmodule

FILE: rtl/tpbb_pixel.sv
// Colour of one pixel: colour bars, grey ramp and the box overlay, in RGB565; black outside the frame.
// Depends on tpbb_pkg.

module tpbb_pixel (
  input  logic [tpbb_pkg::X_W-1:0]   pixel_x,
  input  logic [tpbb_pkg::Y_W-1:0]   pixel_y,
  input  tpbb_pkg::box_pos_t         box,
  output logic [tpbb_pkg::COL_W-1:0] colour
);
  import tpbb_pkg::*;

  logic [2:0]             bar_idx;
  logic [GREY_PROD_W-1:0] grey_prod;
  logic [7:0]             grey;
  logic [COL_W-1:0]       bg;
  logic [X_W:0]           box_right;
  logic [Y_W:0]           box_bottom;
  logic [X_W-1:0]         rx;
  logic [Y_W-1:0]         ry;
  logic                   in_box;
  logic                   on_border;
  logic                   outside;

  always_comb begin
    bar_idx = '0;
    for (int k = 1; k < 8; k++) begin
      if ({1'b0, pixel_x} >= BAR_EDGE[k]) begin
        bar_idx = 3'(k);
      end
    end

    grey_prod = GREY_PROD_W'(pixel_x) * GREY_PROD_W'(GREY_MUL);
    grey = (grey_prod[GREY_PROD_W-1:GREY_SHIFT] > 255) ? 8'hFF : grey_prod[GREY_SHIFT +: 8];

    if ({1'b0, pixel_y} < (Y_W + 1)'(BAR_ROWS)) begin
      bg = BAR_COLOURS[bar_idx];
    end else begin
      bg = {grey[7:3], grey[7:2], grey[7:3]};
    end

    box_right  = {1'b0, box.col} + (X_W + 1)'(BOX_SIZE);
    box_bottom = {1'b0, box.row} + (Y_W + 1)'(BOX_SIZE);
    rx = pixel_x - box.col;
    ry = pixel_y - box.row;
    in_box = (pixel_x >= box.col) && ({1'b0, pixel_x} < box_right) &&
             (pixel_y >= box.row) && ({1'b0, pixel_y} < box_bottom);
    on_border = (rx < X_W'(BORDER_PX)) || (ry < Y_W'(BORDER_PX)) ||
                (rx >= X_W'(BOX_SIZE - BORDER_PX)) || (ry >= Y_W'(BOX_SIZE - BORDER_PX));
    outside = ({1'b0, pixel_x} >= (X_W + 1)'(FRAME_WIDTH)) ||
              ({1'b0, pixel_y} >= (Y_W + 1)'(FRAME_HEIGHT));

    if (outside) begin
      colour = COL_BLACK;
    end else if (in_box) begin
      colour = on_border ? COL_WHITE : COL_BLACK;
    end else begin
      colour = bg;
    end
  end

endmodule

FILE: rtl/test_pattern_bouncing_box.sv
// Bouncing-box test-pattern source: top level with input and result registers.
// A transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle without stalls; the box state updates as
// a tick leaves the input register, so a following query sees the moved box.
// Reset (synchronous, active low): box at the origin moving right and down,
// sequence one, steps three and two, both registers empty.

module test_pattern_bouncing_box (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [tpbb_pkg::STEP_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [tpbb_pkg::X_W-1:0]      in_pixel_x,
  input  logic [tpbb_pkg::Y_W-1:0]      in_pixel_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tpbb_pkg::COL_W-1:0]    out_colour,
  output logic [tpbb_pkg::X_W-1:0]      out_dirty_x,
  output logic [tpbb_pkg::Y_W-1:0]      out_dirty_y,
  output logic [tpbb_pkg::X_W-1:0]      out_dirty_w,
  output logic [tpbb_pkg::Y_W-1:0]      out_dirty_h,
  output logic [tpbb_pkg::SEQ_W-1:0]    out_frame_seq
);
  import tpbb_pkg::*;

  logic [STEP_W-1:0] step_x_r, step_y_r;
  box_pos_t          box_r, box_nxt;
  logic              moving_left_r, moving_left_nxt;
  logic              moving_up_r, moving_up_nxt;
  logic [SEQ_W-1:0]  sequence_r, sequence_nxt;

  logic              s1_valid_r;
  logic              s1_op_r;
  logic [X_W-1:0]    s1_x_r;
  logic [Y_W-1:0]    s1_y_r;
  logic              s1_adv;

  logic              out_valid_r;
  logic [COL_W-1:0]  out_colour_r, out_colour_nxt;
  logic [X_W-1:0]    out_dirty_x_r, out_dirty_x_nxt;
  logic [Y_W-1:0]    out_dirty_y_r, out_dirty_y_nxt;
  logic [X_W-1:0]    out_dirty_w_r, out_dirty_w_nxt;
  logic [Y_W-1:0]    out_dirty_h_r, out_dirty_h_nxt;
  logic [SEQ_W-1:0]  out_seq_r, out_seq_nxt;

  logic [COL_W-1:0]  pix_colour;
  logic [X_W-1:0]    col_moved;
  logic [X_W-1:0]    row_moved;
  logic              left_flip, up_flip;
  logic [X_W-1:0]    x_lo, x_hi;
  logic [Y_W-1:0]    y_lo, y_hi;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || !out_valid_r || out_ready;

  tpbb_axis u_axis_x (
    .pos      (box_r.col),
    .step     (step_x_r),
    .lim      (X_W'(LIM_X)),
    .back     (moving_left_r),
    .pos_nxt  (col_moved),
    .back_nxt (left_flip)
  );

  tpbb_axis u_axis_y (
    .pos      ({{(X_W - Y_W){1'b0}}, box_r.row}),
    .step     (step_y_r),
    .lim      (X_W'(LIM_Y)),
    .back     (moving_up_r),
    .pos_nxt  (row_moved),
    .back_nxt (up_flip)
  );

  tpbb_pixel u_pixel (
    .pixel_x (s1_x_r),
    .pixel_y (s1_y_r),
    .box     (box_r),
    .colour  (pix_colour)
  );

  always_comb begin
    box_nxt         = box_r;
    moving_left_nxt = moving_left_r;
    moving_up_nxt   = moving_up_r;
    sequence_nxt    = sequence_r;
    out_colour_nxt  = '0;
    out_dirty_x_nxt = '0;
    out_dirty_y_nxt = '0;
    out_dirty_w_nxt = '0;
    out_dirty_h_nxt = '0;
    x_lo = '0;
    x_hi = '0;
    y_lo = '0;
    y_hi = '0;
    if (s1_op_r == OP_TICK) begin
      box_nxt.col     = col_moved;
      box_nxt.row     = row_moved[Y_W-1:0];
      moving_left_nxt = left_flip;
      moving_up_nxt   = up_flip;
      sequence_nxt    = sequence_r + 1'b1;
      x_lo = (box_r.col < box_nxt.col) ? box_r.col : box_nxt.col;
      x_hi = (box_r.col > box_nxt.col) ? box_r.col : box_nxt.col;
      y_lo = (box_r.row < box_nxt.row) ? box_r.row : box_nxt.row;
      y_hi = (box_r.row > box_nxt.row) ? box_r.row : box_nxt.row;
      out_dirty_x_nxt = x_lo;
      out_dirty_y_nxt = y_lo;
      out_dirty_w_nxt = x_hi - x_lo + X_W'(BOX_SIZE);
      out_dirty_h_nxt = y_hi - y_lo + Y_W'(BOX_SIZE);
    end else begin
      out_colour_nxt = pix_colour;
    end
    out_seq_nxt = sequence_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_x_r <= STEP_X_RESET;
      step_y_r <= STEP_Y_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_X: step_x_r <= cfg_data;
        REG_STEP_Y: step_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r         <= '0;
      moving_left_r <= 1'b0;
      moving_up_r   <= 1'b0;
      sequence_r    <= 32'd1;
    end else if (s1_adv) begin
      box_r         <= box_nxt;
      moving_left_r <= moving_left_nxt;
      moving_up_r   <= moving_up_nxt;
      sequence_r    <= sequence_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r <= in_op;
      s1_x_r  <= in_pixel_x;
      s1_y_r  <= in_pixel_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_colour_r  <= out_colour_nxt;
      out_dirty_x_r <= out_dirty_x_nxt;
      out_dirty_y_r <= out_dirty_y_nxt;
      out_dirty_w_r <= out_dirty_w_nxt;
      out_dirty_h_r <= out_dirty_h_nxt;
      out_seq_r     <= out_seq_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_colour    = out_colour_r;
  assign out_dirty_x   = out_dirty_x_r;
  assign out_dirty_y   = out_dirty_y_r;
  assign out_dirty_w   = out_dirty_w_r;
  assign out_dirty_h   = out_dirty_h_r;
  assign out_frame_seq = out_seq_r;

`ifndef ASSERT_OFF
  a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_op_r == OP_TICK) |=> (sequence_r == $past(sequence_r) + 1'b1))
    else $error("sequence did not advance on a tick transaction");

  a_query_keeps_box: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_op_r == OP_QUERY) |=> ($stable(box_r) && $stable(sequence_r)))
    else $error("box state changed on a query transaction");

  a_box_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> ((box_r.col <= X_W'(LIM_X)) && (box_r.row <= Y_W'(LIM_Y))))
    else $error("box position beyond the frame limit");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled while the result register is empty");
`endif

endmodule

FILE: sim/test_pattern_bouncing_box_test.sv
// Self-checking testbench for the bouncing-box test-pattern source: directed and
// random pixel queries and frame ticks, checked against a behavioural predictor.
// Depends on rtl/tpbb_pkg.sv and rtl/test_pattern_bouncing_box.sv.

module test_pattern_bouncing_box_test;
  import tpbb_pkg::*;

  typedef struct {
    logic [COL_W-1:0] colour;
    logic [X_W-1:0]   dirty_x;
    logic [Y_W-1:0]   dirty_y;
    logic [X_W-1:0]   dirty_w;
    logic [Y_W-1:0]   dirty_h;
    logic [SEQ_W-1:0] frame_seq;
  } pattern_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_STEP_X;
  logic [STEP_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = OP_QUERY;
  logic [X_W-1:0] in_pixel_x = '0;
  logic [Y_W-1:0] in_pixel_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COL_W-1:0] out_colour;
  logic [X_W-1:0] out_dirty_x;
  logic [Y_W-1:0] out_dirty_y;
  logic [X_W-1:0] out_dirty_w;
  logic [Y_W-1:0] out_dirty_h;
  logic [SEQ_W-1:0] out_frame_seq;

  // Predictor state, mirroring the block.
  logic [X_W-1:0]    box_col;
  logic [Y_W-1:0]    box_row;
  bit                moving_left;
  bit                moving_up;
  logic [SEQ_W-1:0]  frame_count;
  logic [STEP_W-1:0] step_x_q;
  logic [STEP_W-1:0] step_y_q;

  pattern_result_t awaited_results[$];
  bit          idle_en = 1'b1;
  int unsigned sink_hold = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned queries_sent = 0;
  int unsigned ticks_sent = 0;
  int unsigned step_writes = 0;

  test_pattern_bouncing_box u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_pixel_x   (in_pixel_x),
    .in_pixel_y   (in_pixel_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_colour   (out_colour),
    .out_dirty_x  (out_dirty_x),
    .out_dirty_y  (out_dirty_y),
    .out_dirty_w  (out_dirty_w),
    .out_dirty_h  (out_dirty_h),
    .out_frame_seq(out_frame_seq)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [COL_W-1:0] colour_at(int x, int y);
    int rx, ry, bar, grey;
    logic [7:0] g;
    rx = x - int'(box_col);
    ry = y - int'(box_row);
    if (x >= FRAME_WIDTH || y >= FRAME_HEIGHT) return COL_BLACK;
    if (rx >= 0 && rx < BOX_SIZE && ry >= 0 && ry < BOX_SIZE) begin
      if (rx < BORDER_PX || ry < BORDER_PX ||
          rx >= BOX_SIZE - BORDER_PX || ry >= BOX_SIZE - BORDER_PX) return COL_WHITE;
      return COL_BLACK;
    end
    if (y < BAR_ROWS) begin
      bar = (x * 8) / FRAME_WIDTH;
      if (bar > 7) bar = 7;
      return BAR_COLOURS[bar];
    end
    grey = (x * 255) / (FRAME_WIDTH - 1);
    if (grey > 255) grey = 255;
    g = grey[7:0];
    return {g[7:3], g[7:2], g[7:3]};
  endfunction

  // Moves one coordinate, saturating at either edge and reversing there.
  task automatic move_axis_pos(inout int pos, input int step, input int lim, inout bit back);
    if (back) pos = (pos >= step) ? pos - step : 0;
    else pos = (pos + step > lim) ? lim : pos + step;
    if (pos > lim) pos = lim;
    if (pos == 0 || pos >= lim) back = !back;
  endtask

  task automatic predict_result(input logic op, input logic [X_W-1:0] x,
                                input logic [Y_W-1:0] y, output pattern_result_t r);
    int ox, oy, nx, ny, x0, y0, x1, y1;
    r.colour = COL_BLACK;
    r.dirty_x = '0;
    r.dirty_y = '0;
    r.dirty_w = '0;
    r.dirty_h = '0;
    if (op == OP_QUERY) begin
      r.colour = colour_at(int'(x), int'(y));
    end else begin
      ox = int'(box_col);
      oy = int'(box_row);
      nx = ox;
      ny = oy;
      move_axis_pos(nx, int'(step_x_q), LIM_X, moving_left);
      move_axis_pos(ny, int'(step_y_q), LIM_Y, moving_up);
      box_col = X_W'(nx);
      box_row = Y_W'(ny);
      frame_count = frame_count + 1'b1;
      x0 = (ox < nx) ? ox : nx;
      y0 = (oy < ny) ? oy : ny;
      x1 = ((ox > nx) ? ox : nx) + BOX_SIZE;
      y1 = ((oy > ny) ? oy : ny) + BOX_SIZE;
      r.dirty_x = X_W'(x0);
      r.dirty_y = Y_W'(y0);
      r.dirty_w = X_W'(x1 - x0);
      r.dirty_h = Y_W'(y1 - y0);
    end
    r.frame_seq = frame_count;
  endtask

  task automatic issue_request(input logic op, input logic [X_W-1:0] x,
                               input logic [Y_W-1:0] y);
    int unsigned gap;
    pattern_result_t r;
    gap = idle_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_pixel_x <= x;
    in_pixel_y <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_result(op, x, y, r);
    awaited_results.push_back(r);
    if (op == OP_TICK) ticks_sent++;
    else queries_sent++;
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_steps(input logic [STEP_W-1:0] sx, input logic [STEP_W-1:0] sy);
    wait_until_drained();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STEP_X;
    cfg_data  <= sx;
    @(posedge clk);
    step_x_q = sx;
    cfg_index <= REG_STEP_Y;
    cfg_data  <= sy;
    @(posedge clk);
    step_y_q = sy;
    cfg_we <= 1'b0;
    step_writes += 2;
  endtask

  task automatic random_request();
    int pick, x, y;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      issue_request(OP_TICK, X_W'($urandom), Y_W'($urandom));
    end else begin
      if (pick < 45) begin
        x = int'(box_col) + int'($urandom_range(0, BOX_SIZE + 3)) - 2;
        y = int'(box_row) + int'($urandom_range(0, BOX_SIZE + 3)) - 2;
        if (x < 0) x = 0;
        if (y < 0) y = 0;
      end else if (pick < 85) begin
        x = $urandom_range(0, FRAME_WIDTH - 1);
        y = $urandom_range(0, FRAME_HEIGHT - 1);
      end else begin
        x = $urandom_range(0, (1 << X_W) - 1);
        y = $urandom_range(0, (1 << Y_W) - 1);
      end
      issue_request(OP_QUERY, X_W'(x), Y_W'(y));
    end
  endtask

  task automatic test_pattern_queries();
    issue_request(OP_QUERY, 9'd0, 8'd0);
    issue_request(OP_QUERY, 9'd2, 8'd2);
    issue_request(OP_QUERY, 9'd30, 8'd5);
    issue_request(OP_QUERY, 9'd31, 8'd31);
    issue_request(OP_QUERY, 9'd40, 8'd0);
    issue_request(OP_QUERY, 9'd279, 8'd132);
    issue_request(OP_QUERY, 9'd280, 8'd132);
    issue_request(OP_QUERY, 9'd0, 8'd133);
    issue_request(OP_QUERY, 9'd319, 8'd199);
    issue_request(OP_QUERY, 9'd320, 8'd0);
    issue_request(OP_QUERY, 9'd0, 8'd200);
    issue_request(OP_QUERY, 9'd511, 8'd255);
  endtask

  // Large steps drive the box into both far edges, where it saturates and turns.
  task automatic test_edge_saturation();
    set_steps(5'd31, 5'd31);
    repeat (10) issue_request(OP_TICK, 9'd0, 8'd0);
  endtask

  task automatic test_zero_step();
    set_steps(5'd0, 5'd0);
    repeat (3) issue_request(OP_TICK, 9'h1FF, 8'hFF);
  endtask

  task automatic random_phase(input logic [STEP_W-1:0] sx, input logic [STEP_W-1:0] sy,
                              input int count, input bit mid_pause);
    set_steps(sx, sy);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) idle_en = ($urandom_range(0, 3) != 0);
      if (mid_pause && i == count / 2) wait_until_drained();
      random_request();
    end
  endtask

  task automatic test_random_traffic();
    random_phase(5'd1, 5'd1, 240, 1'b0);
    random_phase(5'd31, 5'd31, 240, 1'b1);
    random_phase(5'd0, 5'd31, 235, 1'b0);
    random_phase(5'd31, 5'd0, 235, 1'b0);
    random_phase(STEP_W'($urandom_range(1, 31)), STEP_W'($urandom_range(1, 31)), 240, 1'b1);
    random_phase(STEP_W'($urandom), STEP_W'($urandom), 235, 1'b0);
    idle_en = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sink_hold = idle_en ? $urandom_range(0, 7) : 0;
    else if (sink_hold > 0) sink_hold--;
    out_ready <= rst_n && (sink_hold == 0);
  end

  always @(posedge clk) begin
    pattern_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: colour %h seq %0d", out_colour, out_frame_seq);
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (out_colour !== want.colour || out_dirty_x !== want.dirty_x ||
            out_dirty_y !== want.dirty_y || out_dirty_w !== want.dirty_w ||
            out_dirty_h !== want.dirty_h || out_frame_seq !== want.frame_seq) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch exp %h %0d,%0d %0dx%0d %0d | got %h %0d,%0d %0dx%0d %0d",
                     want.colour, want.dirty_x, want.dirty_y, want.dirty_w, want.dirty_h,
                     want.frame_seq, out_colour, out_dirty_x, out_dirty_y, out_dirty_w,
                     out_dirty_h, out_frame_seq);
        end
      end
    end
  end

  initial begin
    #3200000;
    $display("test_pattern_bouncing_box_test: FAIL");
    $finish;
  end

  initial begin
    box_col     = '0;
    box_row     = '0;
    moving_left = 1'b0;
    moving_up   = 1'b0;
    frame_count = 32'd1;
    step_x_q    = STEP_X_RESET;
    step_y_q    = STEP_Y_RESET;
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_pattern_queries();
    test_edge_saturation();
    test_zero_step();
    test_random_traffic();
    wait_until_drained();
    repeat (6) @(posedge clk);
    $display("Covered %0d pixel queries and %0d frame ticks with %0d step writes.",
             queries_sent, ticks_sent, step_writes);
    $display("Checked %0d result transactions, %0d mismatches.", results_checked,
             mismatch_count);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("test_pattern_bouncing_box_test: PASS");
    end else begin
      $display("test_pattern_bouncing_box_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/tpbb_pkg.sv
rtl/tpbb_axis.sv
rtl/tpbb_pixel.sv
rtl/test_pattern_bouncing_box.sv
sim/test_pattern_bouncing_box_test.sv
